FILE: hdl/foe_pkg.sv
// Shared constants and register codes for the frame allocator with oldest eviction.
`timescale 1ns / 1ps
package foe_pkg;
   localparam int NUM_FRAMES_DEF = 256;
   localparam int PID_W          = 8;
   localparam int MEM_W          = 25;
   localparam int FSZ_W          = 17;
   localparam int STAMP_W        = 32;
   localparam int EVT_W          = 16;
   localparam int OUT_CNT_W      = 9;
   localparam int OUT_FRAME_W    = 8;
   localparam int DIV_STEPS      = MEM_W;
   localparam int DIV_CNT_W      = $clog2(DIV_STEPS + 1);

   localparam logic [MEM_W-1:0] MEM_SIZE_RST   = 25'd65536;
   localparam logic [FSZ_W-1:0] FRAME_SIZE_RST = 17'd256;

   localparam logic CSR_MEMORY_SIZE = 1'b0;
   localparam logic CSR_FRAME_SIZE  = 1'b1;

   localparam logic ACT_ALLOCATE = 1'b0;
   localparam logic ACT_RELEASE  = 1'b1;
endpackage

FILE: hdl/frame_allocator_oldest_eviction.sv
// Frame allocator: sequencer, shared divider, frame table and free queue memories.
// A release is one table scan in flat mode and n+1 scans in paging mode for a process holding
// n frames. An allocate runs the divider in paging mode or a fit scan in flat mode, one oldest
// scan plus a release per eviction, then a queue read and a table write per frame taken in
// paging mode or a table write alone in flat mode. Throughput is one request at a time. Reset
// and every register write clear the table and run the divider before any request is taken.
`timescale 1ns / 1ps
module frame_allocator_oldest_eviction
   import foe_pkg::*;
#(
   parameter int NUM_FRAMES = NUM_FRAMES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_action,
   input  logic [PID_W-1:0]       req_process_id,
   input  logic [MEM_W-1:0]       req_mem_required,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_accepted,
   output logic [OUT_FRAME_W-1:0] rsp_first_frame,
   output logic [OUT_CNT_W-1:0]   rsp_frames_taken,
   output logic [OUT_CNT_W-1:0]   rsp_evictions,
   output logic [EVT_W-1:0]       rsp_paged_out_total,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   csr_index,
   input  logic [MEM_W-1:0]       csr_wdata
);
   localparam int IW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
   localparam int FW = $clog2(NUM_FRAMES + 1);
   localparam int CW = (FW > OUT_CNT_W) ? FW : OUT_CNT_W;
   localparam int XW = (IW > OUT_FRAME_W) ? IW : OUT_FRAME_W;
   localparam logic [FW-1:0]    NF_F   = FW'(NUM_FRAMES);
   localparam logic [FW:0]      NF_F1  = (FW+1)'(NUM_FRAMES);
   localparam logic [MEM_W:0]   NF_W   = (MEM_W+1)'(NUM_FRAMES);
   localparam logic [IW-1:0]    LAST_I = IW'(NUM_FRAMES - 1);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_CLEAR    = 4'd1;
   localparam logic [3:0] S_DIV      = 4'd2;
   localparam logic [3:0] S_FIT      = 4'd3;
   localparam logic [3:0] S_FF_RD    = 4'd4;
   localparam logic [3:0] S_FF_EV    = 4'd5;
   localparam logic [3:0] S_OLD_RD   = 4'd6;
   localparam logic [3:0] S_OLD_EV   = 4'd7;
   localparam logic [3:0] S_REL_RD   = 4'd8;
   localparam logic [3:0] S_REL_EV   = 4'd9;
   localparam logic [3:0] S_REL_FREE = 4'd10;
   localparam logic [3:0] S_REL_DONE = 4'd11;
   localparam logic [3:0] S_POP_RD   = 4'd12;
   localparam logic [3:0] S_POP_WR   = 4'd13;
   localparam logic [3:0] S_FLAT_WR  = 4'd14;
   localparam logic [3:0] S_RESP     = 4'd15;

   // Frame table and free queue.
   logic                 used_mem  [NUM_FRAMES];
   logic [PID_W-1:0]     owner_mem [NUM_FRAMES];
   logic [STAMP_W-1:0]   stamp_mem [NUM_FRAMES];
   logic [IW-1:0]        rank_mem  [NUM_FRAMES];
   logic [IW-1:0]        queue_mem [NUM_FRAMES];

   logic                 used_rd;
   logic [PID_W-1:0]     owner_rd;
   logic [STAMP_W-1:0]   stamp_rd;
   logic [IW-1:0]        rank_rd;
   logic [IW-1:0]        q_rd;

   logic                 tab_we, meta_we, tab_wused, q_we;
   logic [IW-1:0]        tab_waddr, q_waddr, q_wdata, rd_addr, q_raddr;
   logic [IW-1:0]        meta_rank;

   logic [3:0]           state_ff, state_in;
   logic [FW-1:0]        idx_ff, idx_in;
   logic [MEM_W-1:0]     ms_ff, ms_in;
   logic [FSZ_W-1:0]     fs_ff, fs_in;
   logic [FW-1:0]        total_ff, total_in;
   logic [IW-1:0]        head_ff, head_in;
   logic [FW-1:0]        fcount_ff, fcount_in;
   logic [STAMP_W-1:0]   acnt_ff, acnt_in;
   logic [EVT_W-1:0]     evcnt_ff, evcnt_in;
   logic [MEM_W-1:0]     quo_ff, quo_in;
   logic [FSZ_W-1:0]     rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] dcnt_ff, dcnt_in;
   logic                 dcfg_ff, dcfg_in;
   logic [PID_W-1:0]     pid_ff, pid_in;
   logic [FW-1:0]        need_ff, need_in;
   logic [FW-1:0]        k_ff, k_in;
   logic [FW-1:0]        run_ff, run_in;
   logic [IW-1:0]        start_ff, start_in;
   logic [STAMP_W-1:0]   stamp_ff, stamp_in;
   logic                 found_ff, found_in;
   logic [STAMP_W-1:0]   bage_ff, bage_in;
   logic [IW-1:0]        brank_ff, brank_in;
   logic [IW-1:0]        bframe_ff, bframe_in;
   logic [PID_W-1:0]     rpid_ff, rpid_in;
   logic                 revict_ff, revict_in;
   logic                 acc_ff, acc_in;
   logic [IW-1:0]        first_ff, first_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [OUT_CNT_W-1:0] ev_ff, ev_in;
   logic                 rv_ff, rv_in;
   logic                 racc_ff, racc_in;
   logic [OUT_FRAME_W-1:0] rfirst_ff, rfirst_in;
   logic [OUT_CNT_W-1:0] rtaken_ff, rtaken_in;
   logic [OUT_CNT_W-1:0] revs_ff, revs_in;
   logic [EVT_W-1:0]     rtot_ff, rtot_in;

   logic                 paging;
   logic [FSZ_W-1:0]     div_d;
   logic [FSZ_W:0]       div_sh, div_sub;
   logic [MEM_W:0]       div_ceil;
   logic [STAMP_W-1:0]   age;
   logic                 at_end, match;
   logic [FW:0]          tail_sum;
   logic [IW-1:0]        tail;
   logic [IW-1:0]        head_next;
   logic [FW-1:0]        run_next;
   logic [XW-1:0]        first_x;

   assign paging    = (ms_ff != MEM_W'(fs_ff));
   assign div_d     = (fs_ff == '0) ? FSZ_W'(1) : fs_ff;
   assign div_sh    = {rem_ff, quo_ff[MEM_W-1]};
   assign div_sub   = div_sh - {1'b0, div_d};
   assign div_ceil  = {1'b0, quo_ff} + (MEM_W+1)'(rem_ff != '0);
   assign age       = acnt_ff - stamp_rd;
   assign at_end    = (idx_ff == total_ff);
   assign match     = used_rd && (owner_rd == rpid_ff);
   assign tail_sum  = (FW+1)'(head_ff) + (FW+1)'(fcount_ff);
   assign tail      = (tail_sum >= NF_F1) ? IW'(tail_sum - NF_F1) : IW'(tail_sum);
   assign head_next = (head_ff == LAST_I) ? '0 : head_ff + IW'(1);
   assign run_next  = used_rd ? '0 : run_ff + FW'(1);
   assign rd_addr   = idx_ff[IW-1:0];
   assign q_raddr   = head_ff;
   assign meta_rank = k_ff[IW-1:0];
   assign first_x   = XW'(first_ff);

   assign req_stall           = (state_ff != S_IDLE);
   assign csr_ready           = 1'b1;
   assign rsp_valid           = rv_ff;
   assign rsp_accepted        = racc_ff;
   assign rsp_first_frame     = rfirst_ff;
   assign rsp_frames_taken    = rtaken_ff;
   assign rsp_evictions       = revs_ff;
   assign rsp_paged_out_total = rtot_ff;

   always_comb begin
      state_in = state_ff;   idx_in = idx_ff;       ms_in = ms_ff;       fs_in = fs_ff;
      total_in = total_ff;   head_in = head_ff;     fcount_in = fcount_ff;
      acnt_in = acnt_ff;     evcnt_in = evcnt_ff;   quo_in = quo_ff;     rem_in = rem_ff;
      dcnt_in = dcnt_ff;     dcfg_in = dcfg_ff;     pid_in = pid_ff;     need_in = need_ff;
      k_in = k_ff;           run_in = run_ff;       start_in = start_ff; stamp_in = stamp_ff;
      found_in = found_ff;   bage_in = bage_ff;     brank_in = brank_ff; bframe_in = bframe_ff;
      rpid_in = rpid_ff;     revict_in = revict_ff; acc_in = acc_ff;     first_in = first_ff;
      cnt_in = cnt_ff;       ev_in = ev_ff;         rv_in = rv_ff;       racc_in = racc_ff;
      rfirst_in = rfirst_ff; rtaken_in = rtaken_ff; revs_in = revs_ff;   rtot_in = rtot_ff;
      tab_we = 1'b0;  tab_waddr = rd_addr;  tab_wused = 1'b0;  meta_we = 1'b0;
      q_we = 1'b0;    q_waddr = rd_addr;    q_wdata = rd_addr;

      if (rv_ff && !rsp_stall) begin
         rv_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               pid_in = req_process_id;
               acc_in = 1'b0;
               first_in = '0;
               cnt_in = '0;
               ev_in = '0;
               if (req_action == ACT_RELEASE) begin
                  acc_in = 1'b1;
                  rpid_in = req_process_id;
                  revict_in = 1'b0;
                  idx_in = '0;
                  found_in = 1'b0;
                  state_in = S_REL_RD;
               end else if (req_mem_required > ms_ff) begin
                  state_in = S_RESP;
               end else if (paging) begin
                  quo_in = req_mem_required;
                  rem_in = '0;
                  dcnt_in = '0;
                  dcfg_in = 1'b0;
                  state_in = S_DIV;
               end else if (req_mem_required > MEM_W'(total_ff)) begin
                  state_in = S_RESP;
               end else begin
                  need_in = FW'(req_mem_required);
                  state_in = S_FIT;
               end
            end
         end
         S_CLEAR: begin
            tab_we = 1'b1;
            q_we = 1'b1;
            idx_in = idx_ff + FW'(1);
            if (rd_addr == LAST_I) begin
               head_in = '0;
               quo_in = ms_ff;
               rem_in = '0;
               dcnt_in = '0;
               dcfg_in = 1'b1;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (dcnt_ff == DIV_CNT_W'(DIV_STEPS)) begin
               if (dcfg_ff) begin
                  if (paging) begin
                     total_in = (div_ceil > NF_W) ? NF_F : FW'(div_ceil);
                  end else begin
                     total_in = ({1'b0, ms_ff} > NF_W) ? NF_F : FW'(ms_ff);
                  end
                  fcount_in = total_in;
                  state_in = S_IDLE;
               end else if (div_ceil > (MEM_W+1)'(total_ff)) begin
                  state_in = S_RESP;
               end else begin
                  need_in = FW'(div_ceil);
                  state_in = S_FIT;
               end
            end else begin
               dcnt_in = dcnt_ff + DIV_CNT_W'(1);
               if (div_sh >= {1'b0, div_d}) begin
                  rem_in = div_sub[FSZ_W-1:0];
                  quo_in = {quo_ff[MEM_W-2:0], 1'b1};
               end else begin
                  rem_in = div_sh[FSZ_W-1:0];
                  quo_in = {quo_ff[MEM_W-2:0], 1'b0};
               end
            end
         end
         S_FIT: begin
            idx_in = '0;
            run_in = '0;
            found_in = 1'b0;
            if ((paging && need_ff <= fcount_ff) || (!paging && need_ff == '0)) begin
               start_in = '0;
               stamp_in = acnt_ff;
               acnt_in = acnt_ff + STAMP_W'(1);
               acc_in = 1'b1;
               cnt_in = CW'(need_ff);
               k_in = '0;
               state_in = paging ? S_POP_RD : S_FLAT_WR;
            end else begin
               state_in = paging ? S_OLD_RD : S_FF_RD;
            end
         end
         S_FF_RD: begin
            if (at_end) begin
               idx_in = '0;
               state_in = S_OLD_RD;
            end else begin
               state_in = S_FF_EV;
            end
         end
         S_FF_EV: begin
            run_in = run_next;
            idx_in = idx_ff + FW'(1);
            state_in = S_FF_RD;
            if (run_next == need_ff) begin
               start_in = IW'(idx_ff + FW'(1) - need_ff);
               stamp_in = acnt_ff;
               acnt_in = acnt_ff + STAMP_W'(1);
               acc_in = 1'b1;
               cnt_in = CW'(need_ff);
               k_in = '0;
               state_in = S_FLAT_WR;
            end
         end
         S_OLD_RD: begin
            if (at_end) begin
               idx_in = '0;
               if (found_ff) begin
                  found_in = 1'b0;
                  revict_in = 1'b1;
                  state_in = S_REL_RD;
               end else begin
                  state_in = S_RESP;
               end
            end else begin
               state_in = S_OLD_EV;
            end
         end
         S_OLD_EV: begin
            if (used_rd && (!found_ff || age > bage_ff)) begin
               found_in = 1'b1;
               bage_in = age;
               rpid_in = owner_rd;
            end
            idx_in = idx_ff + FW'(1);
            state_in = S_OLD_RD;
         end
         S_REL_RD: begin
            if (at_end) begin
               state_in = (paging && found_ff) ? S_REL_FREE : S_REL_DONE;
            end else begin
               state_in = S_REL_EV;
            end
         end
         S_REL_EV: begin
            if (!paging) begin
               if (match) begin
                  tab_we = 1'b1;
                  if (!revict_ff) begin
                     cnt_in = cnt_ff + CW'(1);
                  end
               end
            end else if (match && (!found_ff || age > bage_ff ||
                                   (age == bage_ff && rank_rd < brank_ff))) begin
               // Oldest allocation first, then the order frames were taken.
               found_in = 1'b1;
               bage_in = age;
               brank_in = rank_rd;
               bframe_in = rd_addr;
            end
            idx_in = idx_ff + FW'(1);
            state_in = S_REL_RD;
         end
         S_REL_FREE: begin
            tab_we = 1'b1;
            tab_waddr = bframe_ff;
            if (fcount_ff < NF_F) begin
               q_we = 1'b1;
               q_waddr = tail;
               q_wdata = bframe_ff;
               fcount_in = fcount_ff + FW'(1);
            end
            if (!revict_ff) begin
               cnt_in = cnt_ff + CW'(1);
            end
            found_in = 1'b0;
            idx_in = '0;
            state_in = S_REL_RD;
         end
         S_REL_DONE: begin
            if (revict_ff) begin
               ev_in = ev_ff + OUT_CNT_W'(1);
               evcnt_in = evcnt_ff + EVT_W'(1);
               state_in = S_FIT;
            end else begin
               state_in = S_RESP;
            end
         end
         S_POP_RD: begin
            state_in = (k_ff == need_ff) ? S_RESP : S_POP_WR;
         end
         S_POP_WR: begin
            tab_we = 1'b1;
            tab_waddr = q_rd;
            tab_wused = 1'b1;
            meta_we = 1'b1;
            if (k_ff == '0) begin
               first_in = q_rd;
            end
            head_in = head_next;
            fcount_in = fcount_ff - FW'(1);
            k_in = k_ff + FW'(1);
            state_in = S_POP_RD;
         end
         S_FLAT_WR: begin
            if (k_ff == need_ff) begin
               state_in = S_RESP;
            end else begin
               tab_we = 1'b1;
               tab_waddr = start_ff + meta_rank;
               tab_wused = 1'b1;
               meta_we = 1'b1;
               if (k_ff == '0) begin
                  first_in = start_ff;
               end
               k_in = k_ff + FW'(1);
            end
         end
         S_RESP: begin
            if (!rv_ff || !rsp_stall) begin
               rv_in = 1'b1;
               racc_in = acc_ff;
               rfirst_in = first_x[OUT_FRAME_W-1:0];
               rtaken_in = cnt_ff[OUT_CNT_W-1:0];
               revs_in = ev_ff;
               rtot_in = evcnt_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // A register write rebuilds the frame table from scratch.
      if (csr_valid) begin
         if (csr_index == CSR_MEMORY_SIZE) begin
            ms_in = csr_wdata;
         end else begin
            fs_in = csr_wdata[FSZ_W-1:0];
         end
         idx_in = '0;
         state_in = S_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (tab_we) begin
         used_mem[tab_waddr] <= tab_wused;
      end
      if (meta_we) begin
         owner_mem[tab_waddr] <= pid_ff;
         stamp_mem[tab_waddr] <= stamp_ff;
         rank_mem[tab_waddr]  <= meta_rank;
      end
      if (q_we) begin
         queue_mem[q_waddr] <= q_wdata;
      end
      used_rd  <= used_mem[rd_addr];
      owner_rd <= owner_mem[rd_addr];
      stamp_rd <= stamp_mem[rd_addr];
      rank_rd  <= rank_mem[rd_addr];
      q_rd     <= queue_mem[q_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         idx_ff   <= '0;
         ms_ff    <= MEM_SIZE_RST;
         fs_ff    <= FRAME_SIZE_RST;
         total_ff <= '0;
         head_ff  <= '0;
         fcount_ff <= '0;
         acnt_ff  <= '0;
         evcnt_ff <= '0;
         dcnt_ff  <= '0;
         dcfg_ff  <= 1'b0;
         found_ff <= 1'b0;
         revict_ff <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         ms_ff    <= ms_in;
         fs_ff    <= fs_in;
         total_ff <= total_in;
         head_ff  <= head_in;
         fcount_ff <= fcount_in;
         acnt_ff  <= acnt_in;
         evcnt_ff <= evcnt_in;
         dcnt_ff  <= dcnt_in;
         dcfg_ff  <= dcfg_in;
         found_ff <= found_in;
         revict_ff <= revict_in;
         rv_ff    <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
      pid_ff    <= pid_in;
      need_ff   <= need_in;
      k_ff      <= k_in;
      run_ff    <= run_in;
      start_ff  <= start_in;
      stamp_ff  <= stamp_in;
      bage_ff   <= bage_in;
      brank_ff  <= brank_in;
      bframe_ff <= bframe_in;
      rpid_ff   <= rpid_in;
      acc_ff    <= acc_in;
      first_ff  <= first_in;
      cnt_ff    <= cnt_in;
      ev_ff     <= ev_in;
      racc_ff   <= racc_in;
      rfirst_ff <= rfirst_in;
      rtaken_ff <= rtaken_in;
      revs_ff   <= revs_in;
      rtot_ff   <= rtot_in;
   end

   a_fcount_range: assert property (@(posedge clock) disable iff (reset)
      fcount_ff <= NF_F && total_ff <= NF_F)
      else $error("free count or frame count beyond the table depth");

   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rv_ff) |-> $past(state_ff == S_RESP))
      else $error("result transfer raised outside the response step");

   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_POP_WR && !csr_valid) |=> fcount_ff == $past(fcount_ff) - FW'(1))
      else $error("queue pop did not reduce the free count");

   a_reject_empty: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && !racc_ff) |-> (rtaken_ff == '0 && rfirst_ff == '0))
      else $error("rejected request reports frames");

   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR || state_ff == S_DIV) |-> req_stall)
      else $error("request taken during rebuild");
endmodule
